FILE: rtl/core/ppm_frame_decoder_unit_assert.svh
// Assertion macros for the PPM frame decoder.
// Used by the top level only; no other dependencies.
`ifndef PPM_FRAME_DECODER_UNIT_ASSERT_SVH
`define PPM_FRAME_DECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property with reset disable.
`define PPMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ppm frame decoder assertion failed");
// Checked property that also holds during reset.
`define PPMD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ppm frame decoder assertion failed");
`else
`define PPMD_ASSERT(lbl, clk, rstn, prop)
`define PPMD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/ppmd_pkg.sv
// Shared types and constants for the PPM frame decoder.
// No dependencies.
package ppmd_pkg;

  localparam int unsigned ChannelsDef = 8;
  localparam int unsigned SlotCntW    = 5;
  localparam int unsigned TsW         = 32;
  localparam int unsigned GapW        = 16;
  localparam int unsigned LockW       = 24;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [GapW-1:0]  SyncGapRst = 16'd3000;
  localparam logic [LockW-1:0] LockoutRst = 24'd100000;

  typedef enum logic {
    ModeEdge = 1'b0,
    ModeRead = 1'b1
  } mode_e;

  typedef enum logic {
    KindStore = 1'b0,
    KindRead  = 1'b1
  } kind_e;

  typedef enum logic {
    RegSyncGap = 1'b0,
    RegLockout = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [TsW-1:0]   ts;
    logic [3:0]       rslot;
  } item_t;

  typedef struct packed {
    logic [GapW-1:0]  gap_min;
    logic [LockW-1:0] lockout;
  } cfg_t;

endpackage

FILE: rtl/core/ppmd_cfg_regs.sv
// APB register file for the PPM frame decoder (sync gap, frame lockout).
// Depends on ppmd_pkg.
module ppmd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppmd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [ppmd_pkg::ApbDataW-1:0]     pwdata,
  output logic [ppmd_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output ppmd_pkg::cfg_t                    cfg_o
);

  ppmd_pkg::cfg_t   cfg_q, cfg_d;
  ppmd_pkg::reg_idx_e idx;
  logic             wr_en;

  // Word addressed: bit 2 picks the register, byte offset bits are ignored.
  assign idx   = ppmd_pkg::reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ppmd_pkg::RegSyncGap: cfg_d.gap_min = pwdata[ppmd_pkg::GapW-1:0];
        ppmd_pkg::RegLockout: cfg_d.lockout = pwdata[ppmd_pkg::LockW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppmd_pkg::RegSyncGap:
        prdata = {{(ppmd_pkg::ApbDataW-ppmd_pkg::GapW){1'b0}}, cfg_q.gap_min};
      ppmd_pkg::RegLockout:
        prdata = {{(ppmd_pkg::ApbDataW-ppmd_pkg::LockW){1'b0}}, cfg_q.lockout};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_min <= ppmd_pkg::SyncGapRst;
      cfg_q.lockout <= ppmd_pkg::LockoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ppmd_in_reg.sv
// Input register stage of the PPM frame decoder.
// Depends on ppmd_pkg.
module ppmd_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [ppmd_pkg::TsW-1:0]  timestamp_us_i,
  input  logic [3:0]                read_slot_i,
  input  logic                      advance_i,
  output ppmd_pkg::item_t           item_o
);

  ppmd_pkg::item_t item_q, item_d;
  logic            accept;

  assign in_stall_o = item_q.valid && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      item_d.valid = 1'b1;
      item_d.mode  = ppmd_pkg::mode_e'(mode_i);
      item_d.ts    = timestamp_us_i;
      item_d.rslot = read_slot_i;
    end else if (advance_i) begin
      item_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/core/ppmd_core.sv
// Frame state, channel store and result register of the PPM frame decoder.
// Depends on ppmd_pkg.
module ppmd_core #(
  parameter int unsigned CHANNELS = ppmd_pkg::ChannelsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ppmd_pkg::item_t           item_i,
  input  ppmd_pkg::cfg_t            cfg_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      kind_o,
  output logic [3:0]                slot_o,
  output logic [ppmd_pkg::TsW-1:0]  width_us_o,
  output logic                      frame_done_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ppmd_pkg::SlotCntW-1:0] ChCnt = ppmd_pkg::SlotCntW'(CHANNELS);

  logic [ppmd_pkg::TsW-1:0]      prev_q, frame_end_q;
  logic [ppmd_pkg::SlotCntW-1:0] next_q, next_inc;
  logic                          armed_q;
  logic [ppmd_pkg::TsW-1:0]      slot_w_q [CHANNELS];

  logic [ppmd_pkg::TsW-1:0] width, since_end, rd_data;
  logic                     is_edge, is_read, locked, sync, store, done, rd_ok;
  logic                     has_res;
  logic [IdxW-1:0]          rd_idx, wr_idx;

  logic                     out_valid_q;
  ppmd_pkg::kind_e          kind_q;
  logic [3:0]               slot_q;
  logic [ppmd_pkg::TsW-1:0] width_q;
  logic                     done_q;

  assign advance_o = item_i.valid && (!out_valid_q || !out_stall_i);
  assign is_edge   = advance_o && (item_i.mode == ppmd_pkg::ModeEdge);
  assign is_read   = advance_o && (item_i.mode == ppmd_pkg::ModeRead);

  assign width     = item_i.ts - prev_q;
  assign since_end = item_i.ts - frame_end_q;
  assign locked    = since_end < {{(ppmd_pkg::TsW-ppmd_pkg::LockW){1'b0}}, cfg_i.lockout};
  assign sync      = width >= {{(ppmd_pkg::TsW-ppmd_pkg::GapW){1'b0}}, cfg_i.gap_min};
  assign store     = is_edge && !locked && !sync && armed_q && (next_q < ChCnt);
  assign next_inc  = next_q + 1'b1;
  assign done      = next_inc >= ChCnt;
  assign wr_idx    = next_q[IdxW-1:0];

  assign rd_ok  = {1'b0, item_i.rslot} < ChCnt;
  assign rd_idx = item_i.rslot[IdxW-1:0];
  assign rd_data = rd_ok ? slot_w_q[rd_idx] : '0;

  assign has_res = is_read || store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      frame_end_q <= '0;
      next_q      <= '0;
      armed_q     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_w_q[i] <= '0;
      end
    end else if (is_edge) begin
      prev_q <= item_i.ts;
      if (!locked && sync) begin
        next_q  <= '0;
        armed_q <= 1'b1;
      end else if (store) begin
        slot_w_q[wr_idx] <= width;
        next_q           <= next_inc;
        if (done) begin
          frame_end_q <= item_i.ts;
          armed_q     <= 1'b0;
        end
      end
    end
  end

  // Result register: refilled on every advance, drained when not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= has_res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && has_res) begin
      if (is_read) begin
        kind_q  <= ppmd_pkg::KindRead;
        slot_q  <= item_i.rslot;
        width_q <= rd_data;
        done_q  <= 1'b0;
      end else begin
        kind_q  <= ppmd_pkg::KindStore;
        slot_q  <= next_q[3:0];
        width_q <= width;
        done_q  <= done;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign width_us_o   = width_q;
  assign frame_done_o = done_q;

endmodule

FILE: rtl/core/ppm_frame_decoder_unit.sv
// PPM frame decoder: input register stage, state update and result register.
// Depends on ppmd_pkg, ppmd_cfg_regs, ppmd_in_reg, ppmd_core and the assert header.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries either an edge
// event (mode 0, timestamp_us_i) or a read request (mode 1, read_slot_i).
// Edge events update the stored edge time; a sync gap arms capture, and while
// armed each pulse width is stored and reported (kind 0) with frame_done_o set
// on the last channel. Reads return one stored width (kind 1), 0 beyond the
// channel count. Results leave on out_valid_o / out_stall_i.
// From input transfer to the earliest result transfer, an item passes through
// the input register, then the state update feeding the result register.
// Throughput is one item per cycle; the result register decouples the sides,
// and the input register is only held while a result waits under stall.
// Items that yield no result pass through even while the output is stalled
// only when the result register is empty.
// Reset clears the frame state, the channel store and both valid bits at once;
// registers return to sync gap 3000 us and lockout 100000 us.
// Config (APB, word addressed): 0x0 sync gap, 0x4 frame lockout; write idle.
module ppm_frame_decoder_unit #(
  parameter int unsigned CHANNELS = ppmd_pkg::ChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppmd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [ppmd_pkg::ApbDataW-1:0]   pwdata,
  output logic [ppmd_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [ppmd_pkg::TsW-1:0]        timestamp_us_i,
  input  logic [3:0]                      read_slot_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [3:0]                      slot_o,
  output logic [ppmd_pkg::TsW-1:0]        width_us_o,
  output logic                            frame_done_o
);

`include "ppm_frame_decoder_unit_assert.svh"

  localparam logic [ppmd_pkg::SlotCntW-1:0] ChCnt = ppmd_pkg::SlotCntW'(CHANNELS);

  ppmd_pkg::cfg_t  cfg;
  ppmd_pkg::item_t item;
  logic            advance;
  logic            slot_in_range;

  ppmd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppmd_in_reg u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .timestamp_us_i (timestamp_us_i),
    .read_slot_i    (read_slot_i),
    .advance_i      (advance),
    .item_o         (item)
  );

  ppmd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cfg_i        (cfg),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .width_us_o   (width_us_o),
    .frame_done_o (frame_done_o)
  );

  assign slot_in_range = {1'b0, slot_o} < ChCnt;

  // Input is held back only while the staged item cannot move on.
  `PPMD_ASSERT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> (item.valid && out_stall_i))
  // A stored report always names a slot inside the channel count.
  `PPMD_ASSERT(a_store_slot_range, clk_i, rst_ni, (out_valid_o && !kind_o) |-> slot_in_range)
  // Frame end is only ever flagged on a store report.
  `PPMD_ASSERT(a_done_on_store, clk_i, rst_ni, (out_valid_o && frame_done_o) |-> !kind_o)
  // Nothing waits to leave while reset is held.
  `PPMD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!out_valid_o || rst_ni))

endmodule
